[hdl/pdr_pkg.sv]
`timescale 1ns / 1ps

package pdr_pkg;

  // Default build options.
  localparam int CordicStepsDef = 16;
  localparam int PosWidthDef    = 32;

  // CORDIC start value (gain of the full iteration) in Q1.30.
  localparam logic signed [31:0] CordicGain  = 32'sd652032875;
  // A quarter turn as a signed binary angle.
  localparam logic signed [31:0] QuarterTurn = 32'sd1073741824;

  // Register reset values.
  localparam logic [23:0]        TimeStepRst  = 24'd1677722;
  localparam logic signed [31:0] WallLimitRst = 32'sd13107;

  // Configuration register indexes.
  localparam logic CfgTimeStep  = 1'b0;
  localparam logic CfgWallLimit = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL_H  = 9'b000000010,
    S_HEAD   = 9'b000000100,
    S_VEL    = 9'b000001000,
    S_CORD   = 9'b000010000,
    S_MUL_X  = 9'b000100000,
    S_MUL_Y  = 9'b001000000,
    S_ADD_Y  = 9'b010000000,
    S_FINISH = 9'b100000000
  } pdr_state_e;

  // Status and results handed from the CORDIC to the sequencer.
  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_val;
    logic signed [31:0] sin_val;
  } pdr_cordic_res_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] pdr_atan(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      5'd24:   val = 32'd41;
      5'd25:   val = 32'd20;
      5'd26:   val = 32'd10;
      5'd27:   val = 32'd5;
      5'd28:   val = 32'd3;
      5'd29:   val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

[hdl/pose_dead_reckoning_integrator.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: motion and pose fields, tuser: mode
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: pose and bumper flag
// cfg       in         cfg_we_i (always taken)      cfg_idx_i, cfg_data_i
//
// A drive result passes MUL_H, HEAD, VEL, the CORDIC loop (one iteration per cycle),
// MUL_X, MUL_Y, ADD_Y and FINISH; four products share one multiplier.
// A teleport result goes straight to FINISH. The input is not ready while a request
// is in work and returns with the result, so a request starts only once the last
// result is registered.
// Reset clears the pose and loads the register defaults.
// A stalled result holds the block in its last step; nothing is lost.
module pose_dead_reckoning_integrator #(
  parameter int CORDIC_STEPS = pdr_pkg::CordicStepsDef,
  parameter int POS_WIDTH    = pdr_pkg::PosWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // lin_speed[23:0], ang_speed[47:24], set_x[79:48], set_y[111:80], set_heading[143:112]
  input  logic [143:0] s_axis_tdata,
  // mode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], pose_heading[95:64], bumper_hit[96], zero[103:97]
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  // Position registers hold at least the 32-bit teleport value.
  localparam int XW = (POS_WIDTH > 32) ? POS_WIDTH : 32;

  pdr_pkg::pdr_state_e state_q, state_d;

  logic [23:0]         time_step_q;
  logic signed [31:0]  wall_limit_q;
  logic signed [XW-1:0] x_q, y_q;
  logic [31:0]         heading_q;
  logic signed [23:0]  lin_q, ang_q;
  logic signed [31:0]  v_q;
  logic                out_valid_q;
  logic [103:0]        out_data_q;

  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod, prod_h, prod_v, prod_p;
  logic signed [25:0]  dpos;
  logic signed [XW-1:0] x_sum, y_sum;
  logic signed [POS_WIDTH-1:0] x_wrap, y_wrap;
  logic                in_acc, out_free, bumper;
  logic                cord_start;
  logic [31:0]         set_x, set_y;
  pdr_pkg::pdr_cordic_res_t cord_res;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign set_x    = s_axis_tdata[79:48];
  assign set_y    = s_axis_tdata[111:80];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q  <= pdr_pkg::TimeStepRst;
      wall_limit_q <= pdr_pkg::WallLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdr_pkg::CfgTimeStep:  time_step_q  <= cfg_data_i[23:0];
        pdr_pkg::CfgWallLimit: wall_limit_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      pdr_pkg::S_MUL_H: begin
        mul_a = 32'(ang_q);
        mul_b = $signed({8'd0, time_step_q});
      end
      pdr_pkg::S_HEAD: begin
        mul_a = 32'(lin_q);
        mul_b = $signed({8'd0, time_step_q});
      end
      pdr_pkg::S_MUL_X: begin
        mul_a = v_q;
        mul_b = cord_res.cos_val;
      end
      pdr_pkg::S_MUL_Y: begin
        mul_a = v_q;
        mul_b = cord_res.sin_val;
      end
      default: ;
    endcase
  end

  pdr_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pdr_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (heading_q),
    .res_o   (cord_res)
  );

  assign cord_start = (state_q == pdr_pkg::S_VEL);

  // Rounded scalings of the product: half up, then floor.
  assign prod_h = prod + 64'sd128;
  assign prod_v = prod + 64'sd32768;
  assign prod_p = prod + (64'sd1 <<< 37);
  assign dpos   = prod_p[63:38];

  // Position steps wrap at the position width.
  assign x_sum  = x_q + XW'(dpos);
  assign y_sum  = y_q + XW'(dpos);
  assign x_wrap = x_sum[POS_WIDTH-1:0];
  assign y_wrap = y_sum[POS_WIDTH-1:0];

  assign bumper = x_q < XW'(wall_limit_q);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdr_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = s_axis_tuser ? pdr_pkg::S_FINISH : pdr_pkg::S_MUL_H;
        end
      end
      pdr_pkg::S_MUL_H: state_d = pdr_pkg::S_HEAD;
      pdr_pkg::S_HEAD:  state_d = pdr_pkg::S_VEL;
      pdr_pkg::S_VEL:   state_d = pdr_pkg::S_CORD;
      pdr_pkg::S_CORD: begin
        if (cord_res.done) begin
          state_d = pdr_pkg::S_MUL_X;
        end
      end
      pdr_pkg::S_MUL_X: state_d = pdr_pkg::S_MUL_Y;
      pdr_pkg::S_MUL_Y: state_d = pdr_pkg::S_ADD_Y;
      pdr_pkg::S_ADD_Y: state_d = pdr_pkg::S_FINISH;
      pdr_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = pdr_pkg::S_IDLE;
        end
      end
      default: state_d = pdr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pose state, updated step by step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      heading_q <= '0;
    end else begin
      if (state_q == pdr_pkg::S_IDLE && in_acc && s_axis_tuser) begin
        x_q       <= XW'($signed(set_x));
        y_q       <= XW'($signed(set_y));
        heading_q <= s_axis_tdata[143:112];
      end
      if (state_q == pdr_pkg::S_HEAD) begin
        heading_q <= heading_q + prod_h[39:8];
      end
      if (state_q == pdr_pkg::S_MUL_Y) begin
        x_q <= XW'(x_wrap);
      end
      if (state_q == pdr_pkg::S_ADD_Y) begin
        y_q <= XW'(y_wrap);
      end
    end
  end

  // Captured motion inputs and velocity term.
  always_ff @(posedge clk_i) begin
    if (state_q == pdr_pkg::S_IDLE && in_acc) begin
      lin_q <= $signed(s_axis_tdata[23:0]);
      ang_q <= $signed(s_axis_tdata[47:24]);
    end
    if (state_q == pdr_pkg::S_VEL) begin
      v_q <= prod_v[47:16];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == pdr_pkg::S_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pdr_pkg::S_FINISH && out_free) begin
      out_data_q <= {7'd0, bumper, heading_q, y_q[31:0], x_q[31:0]};
    end
  end

  assign s_axis_tready = (state_q == pdr_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // An accepted request blocks the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after an accepted request");

  // A teleport goes straight to the result step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> (state_q == pdr_pkg::S_FINISH))
    else $error("teleport did not go to the result step");

  // The CORDIC only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_res.done |-> (state_q == pdr_pkg::S_CORD))
    else $error("CORDIC finished outside its wait step");

  // A waiting result is never replaced before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result changed");

endmodule

[hdl/pdr_mult.sv]
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module pdr_mult (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  // The product is registered: it is ready in the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[hdl/pdr_cordic.sv]
`timescale 1ns / 1ps

// Iterative CORDIC rotator: one add-shift step per cycle.
module pdr_cordic #(
  parameter int CORDIC_STEPS = pdr_pkg::CordicStepsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               angle_i,
  output pdr_pkg::pdr_cordic_res_t  res_o
);

  localparam int CntW = $clog2(CORDIC_STEPS);

  logic                busy_q, done_q, flip_q;
  logic [CntW-1:0]     cnt_q;
  logic signed [31:0]  x_q, y_q;
  logic signed [32:0]  z_q;
  logic signed [31:0]  angle_s;
  logic                need_flip;
  logic signed [31:0]  shx, shy;
  logic signed [32:0]  atan_val;

  // Headings beyond a quarter turn are rotated by half a turn first.
  assign angle_s   = $signed(angle_i);
  assign need_flip = (angle_s > pdr_pkg::QuarterTurn) || (angle_s < -pdr_pkg::QuarterTurn);

  // Shared shifter and table lookup for the current step.
  assign shx      = y_q >>> cnt_q;
  assign shy      = x_q >>> cnt_q;
  assign atan_val = $signed({1'b0, pdr_pkg::pdr_atan(5'(cnt_q))});

  // Control state of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath of the rotation.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= pdr_pkg::CordicGain;
      y_q    <= '0;
      flip_q <= need_flip;
      if (need_flip) begin
        z_q <= 33'($signed({~angle_i[31], angle_i[30:0]}));
      end else begin
        z_q <= 33'(angle_s);
      end
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - shx;
        y_q <= y_q + shy;
        z_q <= z_q - atan_val;
      end else begin
        x_q <= x_q + shx;
        y_q <= y_q - shy;
        z_q <= z_q + atan_val;
      end
    end
  end

  assign res_o.done    = done_q;
  assign res_o.cos_val = flip_q ? -x_q : x_q;
  assign res_o.sin_val = flip_q ? -y_q : y_q;

endmodule

[bench/pdr_pose_monitor.sv]
`timescale 1ns / 1ps

module pdr_pose_monitor #(
  parameter int CORDIC_STEPS = pdr_pkg::CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // lin_speed[23:0], ang_speed[47:24], set_x[79:48], set_y[111:80], set_heading[143:112]
  input  logic [143:0] s_axis_tdata,
  // mode[0]
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], pose_heading[95:64], bumper_hit[96], zero[103:97]
  input  logic [103:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output int           errors_o,
  output int           pending_o
);

  localparam logic ModeTeleport = 1'b1;

  localparam longint GainQ30     = 652032875;
  localparam longint QuarterTurn = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic               bumper;
  } pose_t;

  // Arctangent of 2^-i, binary angle with a full turn at 2^32.
  longint arc_tab [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  pose_t              pose_q;
  logic [23:0]        step_q;
  logic signed [31:0] wall_q;
  pose_t              poses_due[$];

  // Arithmetic right shift that rounds half up.
  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Cosine and sine of a binary angle in Q1.30; the outer half turn is folded in.
  function automatic void cordic_rotate(input logic [31:0] angle, output longint cs,
                                        output longint sn);
    longint z, xr, yr, dxr, dyr;
    bit     flip;
    z    = longint'($signed(angle));
    flip = 1'b0;
    if (z > QuarterTurn || z < -QuarterTurn) begin
      z    = longint'($signed(angle + 32'h8000_0000));
      flip = 1'b1;
    end
    xr = GainQ30;
    yr = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      dxr = yr >>> i;
      dyr = xr >>> i;
      if (z >= 0) begin
        xr = xr - dxr;
        yr = yr + dyr;
        z  = z - arc_tab[i];
      end else begin
        xr = xr + dxr;
        yr = yr - dyr;
        z  = z + arc_tab[i];
      end
    end
    cs = flip ? -xr : xr;
    sn = flip ? -yr : yr;
  endfunction

  // Pose after one request, under the current time step and wall limit.
  function automatic pose_t next_pose(input pose_t cur, input logic mode,
                                      input logic signed [23:0] lin,
                                      input logic signed [23:0] ang,
                                      input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] hd);
    pose_t  upd;
    longint dt, turn, vel, cs, sn, dx, dy;
    upd = cur;
    if (mode == ModeTeleport) begin
      upd.pos_x   = px;
      upd.pos_y   = py;
      upd.heading = hd;
    end else begin
      dt          = longint'(step_q);
      turn        = round_shr(longint'(lin) * 0 + longint'(ang) * dt, 8);
      upd.heading = cur.heading + turn[31:0];
      cordic_rotate(upd.heading, cs, sn);
      vel         = round_shr(longint'(lin) * dt, 16);
      dx          = round_shr(vel * cs, 38);
      dy          = round_shr(vel * sn, 38);
      upd.pos_x   = cur.pos_x + dx[31:0];
      upd.pos_y   = cur.pos_y + dy[31:0];
    end
    upd.bumper = (upd.pos_x < wall_q);
    return upd;
  endfunction

  // Track register writes, predict each accepted request and compare each result.
  always @(posedge clk_i or negedge rst_ni) begin : track
    pose_t want;
    pose_t upd;
    if (!rst_ni) begin
      pose_q    = '0;
      step_q    = pdr_pkg::TimeStepRst;
      wall_q    = pdr_pkg::WallLimitRst;
      poses_due.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pdr_pkg::CfgTimeStep:  step_q = cfg_data_i[23:0];
          pdr_pkg::CfgWallLimit: wall_q = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (poses_due.size() == 0) begin
          $display("%0t: result with no request pending, got %h", $time, m_axis_tdata);
          errors_o = errors_o + 1;
        end else begin
          want = poses_due.pop_front();
          if (m_axis_tdata[31:0] !== want.pos_x) begin
            $display("%0t: pos_x expected %h got %h", $time, want.pos_x, m_axis_tdata[31:0]);
            errors_o = errors_o + 1;
          end
          if (m_axis_tdata[63:32] !== want.pos_y) begin
            $display("%0t: pos_y expected %h got %h", $time, want.pos_y,
                     m_axis_tdata[63:32]);
            errors_o = errors_o + 1;
          end
          if (m_axis_tdata[95:64] !== want.heading) begin
            $display("%0t: pose_heading expected %h got %h", $time, want.heading,
                     m_axis_tdata[95:64]);
            errors_o = errors_o + 1;
          end
          if (m_axis_tdata[96] !== want.bumper) begin
            $display("%0t: bumper_hit expected %b got %b", $time, want.bumper,
                     m_axis_tdata[96]);
            errors_o = errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        upd = next_pose(pose_q, s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[47:24],
                        s_axis_tdata[79:48], s_axis_tdata[111:80], s_axis_tdata[143:112]);
        pose_q = upd;
        poses_due.push_back(upd);
      end
      pending_o = poses_due.size();
    end
  end

endmodule

[bench/pose_dead_reckoning_integrator_test.sv]
`timescale 1ns / 1ps

module pose_dead_reckoning_integrator_test;

  localparam logic ModeDrive    = 1'b0;
  localparam logic ModeTeleport = 1'b1;

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int StallLimit = 2000;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [31:0]  cfg_data_i;
  int           errors;
  int           pending;
  int           stall_cycles;
  logic         calm;
  logic [31:0]  wall_now;

  pose_dead_reckoning_integrator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  pdr_pose_monitor monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The result side stalls at random unless a calm stretch is running.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 22);
  end

  // Watchdog on forward progress of either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  // Present one request and hold it until accepted; valid stays high afterwards.
  task automatic send_req(input logic mode, input logic [23:0] lin, input logic [23:0] ang,
                          input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] hd);
    if (!calm) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {hd, py, px, ang, lin};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drive request; the teleport fields carry noise.
  task automatic drive_req(input logic [23:0] lin, input logic [23:0] ang);
    send_req(ModeDrive, lin, ang, $urandom, $urandom, $urandom);
  endtask

  // Teleport request; the speed fields carry noise.
  task automatic jump_req(input logic [31:0] px, input logic [31:0] py, input logic [31:0] hd);
    send_req(ModeTeleport, 24'($urandom), 24'($urandom), px, py, hd);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write both registers while the block is idle.
  task automatic load_settings(input logic [31:0] step_word, input logic [31:0] wall_word);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pdr_pkg::CfgTimeStep;
    cfg_data_i <= step_word;
    @(negedge clk_i);
    cfg_idx_i  <= pdr_pkg::CfgWallLimit;
    cfg_data_i <= wall_word;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    wall_now   = wall_word;
  endtask

  function automatic logic [23:0] pick_speed();
    logic [23:0] r;
    case ($urandom_range(4))
      0: r = 24'($urandom_range(131072)) - 24'd65536;
      1: r = $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
      2: r = 24'($urandom_range(2)) - 24'd1;
      default: r = 24'($urandom);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_heading();
    logic [31:0] r;
    case ($urandom_range(3))
      0: r = 32'h4000_0000 + $urandom_range(8) - 32'd4;
      1: r = 32'hC000_0000 + $urandom_range(8) - 32'd4;
      2: r = ($urandom_range(1) ? 32'h8000_0000 : 32'h0) + $urandom_range(8) - 32'd4;
      default: r = $urandom;
    endcase
    return r;
  endfunction

  // Random requests: mostly drive steps, with teleports partly near the wall and quadrant edges.
  task automatic random_phase(input int count, input int calm_items);
    int          pause_at;
    logic [31:0] px;
    pause_at = $urandom_range(count - 1);
    for (int i = 0; i < count; i++) begin
      calm = (i < calm_items);
      if (i == pause_at) drain();
      if ($urandom_range(99) < 20) begin
        px = $urandom_range(1) ? $urandom : wall_now + $urandom_range(8) - 32'd4;
        jump_req(px, $urandom, pick_heading());
      end else begin
        drive_req(pick_speed(), pick_speed());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ModeDrive;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = pdr_pkg::CfgTimeStep;
    cfg_data_i    = '0;
    stall_cycles  = 0;
    calm          = 1'b0;
    wall_now      = pdr_pkg::WallLimitRst;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset register values.
    drive_req(24'h00_0000, 24'h00_0000);
    drive_req(24'h7F_FFFF, 24'h00_0000);
    drive_req(24'h80_0000, 24'h7F_FFFF);
    drive_req(24'h7F_FFFF, 24'h80_0000);
    jump_req(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    drive_req(24'h7F_FFFF, 24'h00_0000);
    // Positions wrap past the largest value.
    jump_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    drive_req(24'h7F_FFFF, 24'h00_0000);
    // Bumper just below and exactly at the wall; headings on the quadrant edges.
    jump_req(32'd13106, 32'd0, 32'h4000_0000);
    drive_req(24'h01_0000, 24'h00_0000);
    jump_req(32'd13107, 32'd0, 32'hC000_0000);
    drive_req(24'h01_0000, 24'h00_0000);
    jump_req(32'd0, 32'd0, 32'h4000_0001);
    drive_req(24'hFF_0000, 24'h00_0000);
    jump_req(32'd0, 32'd0, 32'h8000_0000);
    drive_req(24'h01_0000, 24'h00_0000);
    jump_req(32'd0, 32'd0, 32'hBFFF_FFFF);
    drive_req(24'h01_0000, 24'h00_0000);
    // Heading rounding for the smallest turn rates in both directions.
    drive_req(24'h00_0001, 24'h00_0001);
    drive_req(24'hFF_FFFF, 24'hFF_FFFF);
    jump_req(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
    drive_req(24'h80_0000, 24'h80_0000);

    // Longest time step, wall at the most negative position.
    load_settings(32'hA5FF_FFFF, 32'h8000_0000);
    random_phase(120, 0);
    // Smallest non-zero time step, wall at the most positive position.
    load_settings(32'h0000_0001, 32'h7FFF_FFFF);
    random_phase(60, 0);
    // Zero time step leaves the pose unchanged on drive requests.
    load_settings(32'h5A00_0000, 32'h0000_0000);
    random_phase(20, 0);
    // Random settings, the first with a stretch of no stalls on either side.
    load_settings(32'($urandom_range(16777215, 1)), $urandom);
    random_phase(130, 80);
    load_settings(32'($urandom_range(16777215, 1)), $urandom);
    random_phase(130, 0);
    load_settings(32'($urandom_range(16777215, 1)), $urandom);
    random_phase(130, 0);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (pending != 0) begin
      $display("%0t: %0d pose results never arrived", $time, pending);
    end
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
